### sv/bsfd_pkg.sv
// Shared types and constants for the byte stream frame deframer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bsfd_pkg;

    // Width of the payload length counter; a declared length must fit in it
    localparam int LEN_WIDTH = 24;

    localparam int MARKER_W   = 16;
    localparam int MAX_LEN_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [LEN_WIDTH-1:0] pos_t;

    // Parser phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_END     = 2'd2;

    // Header byte positions
    localparam pos_t HDR_START_END = pos_t'(2);
    localparam pos_t HDR_ID_END    = pos_t'(6);
    localparam pos_t HDR_TYPE      = pos_t'(6);
    localparam pos_t HDR_LEN_END   = pos_t'(11);
    localparam pos_t HDR_CHANNEL   = pos_t'(11);
    localparam pos_t HDR_BYTES     = pos_t'(12);

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_END   = 3'd2;
    localparam logic [2:0] ST_ZERO_BYTE = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

    localparam logic [MARKER_W-1:0]  START_MARKER_RST = 16'heaff;
    localparam logic [MARKER_W-1:0]  END_MARKER_RST   = 16'haadd;
    localparam logic [MAX_LEN_W-1:0] MAX_PAYLOAD_RST  = 24'd4096;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [31:0] packet_id;
        logic [7:0]  data_type;
        logic [31:0] payload_length;
        logic [7:0]  channel_id;
        logic [2:0]  status;
    } result_t;

endpackage

`default_nettype wire

### sv/bsfd_parser.sv
// Frame parser: configuration registers, parse state and the per-byte decode.
// Depends on bsfd_pkg.
`default_nettype none

module bsfd_parser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic [7:0]                         data,
    input  wire logic                               cfg_we,
    input  wire logic [bsfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bsfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bsfd_pkg::result_t                       res,
    output logic                                    has_res
);

    logic [bsfd_pkg::MARKER_W-1:0]  start_marker_reg;
    logic [bsfd_pkg::MARKER_W-1:0]  end_marker_reg;
    logic [bsfd_pkg::MAX_LEN_W-1:0] max_payload_reg;

    logic [1:0]      phase_reg, phase_next;
    bsfd_pkg::pos_t  pos_reg, pos_next;
    logic [15:0]     start_word_reg, start_word_next;
    logic [31:0]     packet_id_reg, packet_id_next;
    logic [7:0]      type_reg, type_next;
    logic [31:0]     length_reg, length_next;
    logic [7:0]      channel_reg, channel_next;
    logic [7:0]      end_high_reg, end_high_next;
    logic            saw_zero_reg, saw_zero_next;

    bsfd_pkg::pos_t  hdr_pos;
    logic [32:0]     pos_inc_wide;
    logic            last;
    logic            too_long;
    logic [15:0]     end_word;
    logic [2:0]      code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= bsfd_pkg::START_MARKER_RST;
            end_marker_reg   <= bsfd_pkg::END_MARKER_RST;
            max_payload_reg  <= bsfd_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bsfd_pkg::REG_START_MARKER)
                start_marker_reg <= cfg_data[bsfd_pkg::MARKER_W-1:0];
            else if (cfg_index == bsfd_pkg::REG_END_MARKER)
                end_marker_reg <= cfg_data[bsfd_pkg::MARKER_W-1:0];
            else if (cfg_index == bsfd_pkg::REG_MAX_PAYLOAD)
                max_payload_reg <= cfg_data[bsfd_pkg::MAX_LEN_W-1:0];
        end
    end

    assign pos_inc_wide = 33'(pos_reg) + 33'd1;
    assign last         = (pos_inc_wide == {1'b0, length_reg});
    assign too_long     = (length_reg > 32'(max_payload_reg))
                       || ((length_reg >> bsfd_pkg::LEN_WIDTH) != 32'd0);
    assign end_word     = {end_high_reg, data};
    assign hdr_pos      = (pos_reg >= bsfd_pkg::HDR_BYTES) ? '0 : pos_reg;

    always_comb
    begin
        priority if (start_word_reg != start_marker_reg)
            code = bsfd_pkg::ST_BAD_START;
        else if (end_word != end_marker_reg)
            code = bsfd_pkg::ST_BAD_END;
        else if (saw_zero_reg)
            code = bsfd_pkg::ST_ZERO_BYTE;
        else
            code = bsfd_pkg::ST_OK;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        start_word_next = start_word_reg;
        packet_id_next  = packet_id_reg;
        type_next       = type_reg;
        length_next     = length_reg;
        channel_next    = channel_reg;
        end_high_next   = end_high_reg;
        saw_zero_next   = saw_zero_reg;
        res             = '0;
        has_res         = 1'b0;

        unique case (phase_reg)
            bsfd_pkg::PH_PAYLOAD:
            begin
                if (data == 8'd0)
                    saw_zero_next = 1'b1;
                pos_next = pos_reg + bsfd_pkg::pos_t'(1);
                if (last)
                begin
                    phase_next = bsfd_pkg::PH_END;
                    pos_next   = '0;
                end
                has_res          = 1'b1;
                res.kind         = bsfd_pkg::KIND_PAYLOAD;
                res.payload_byte = data;
                res.payload_last = last;
            end
            bsfd_pkg::PH_END:
            begin
                if (pos_reg == '0)
                begin
                    end_high_next = data;
                    pos_next      = bsfd_pkg::pos_t'(1);
                end
                else
                begin
                    has_res            = 1'b1;
                    res.kind           = bsfd_pkg::KIND_STATUS;
                    res.packet_id      = packet_id_reg;
                    res.data_type      = type_reg;
                    res.payload_length = length_reg;
                    res.channel_id     = channel_reg;
                    res.status         = code;
                    phase_next         = bsfd_pkg::PH_HEADER;
                    pos_next           = '0;
                end
            end
            default:
            begin
                // header phase; the unused phase code lands here too
                phase_next = bsfd_pkg::PH_HEADER;
                if (hdr_pos == '0)
                    saw_zero_next = 1'b0;

                priority if (hdr_pos < bsfd_pkg::HDR_START_END)
                    start_word_next = {start_word_reg[7:0], data};
                else if (hdr_pos < bsfd_pkg::HDR_ID_END)
                    packet_id_next = {packet_id_reg[23:0], data};
                else if (hdr_pos == bsfd_pkg::HDR_TYPE)
                    type_next = data;
                else if (hdr_pos < bsfd_pkg::HDR_LEN_END)
                    length_next = {length_reg[23:0], data};
                else
                    channel_next = data;

                if (hdr_pos == bsfd_pkg::HDR_CHANNEL)
                begin
                    pos_next = '0;
                    if (too_long)
                    begin
                        has_res            = 1'b1;
                        res.kind           = bsfd_pkg::KIND_STATUS;
                        res.packet_id      = packet_id_reg;
                        res.data_type      = type_reg;
                        res.payload_length = length_reg;
                        res.channel_id     = data;
                        res.status         = bsfd_pkg::ST_TOO_LONG;
                    end
                    else if (length_reg == 32'd0)
                        phase_next = bsfd_pkg::PH_END;
                    else
                        phase_next = bsfd_pkg::PH_PAYLOAD;
                end
                else
                    pos_next = hdr_pos + bsfd_pkg::pos_t'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bsfd_pkg::PH_HEADER;
            pos_reg        <= '0;
            start_word_reg <= '0;
            packet_id_reg  <= '0;
            type_reg       <= '0;
            length_reg     <= '0;
            channel_reg    <= '0;
            end_high_reg   <= '0;
            saw_zero_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            start_word_reg <= start_word_next;
            packet_id_reg  <= packet_id_next;
            type_reg       <= type_next;
            length_reg     <= length_next;
            channel_reg    <= channel_next;
            end_high_reg   <= end_high_next;
            saw_zero_reg   <= saw_zero_next;
        end
    end

    // payload count never reaches the declared length
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bsfd_pkg::PH_PAYLOAD |-> 33'(pos_reg) < {1'b0, length_reg})
        else $error("payload position past declared length");

    // end word takes exactly two bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bsfd_pkg::PH_END |-> pos_reg <= bsfd_pkg::pos_t'(1))
        else $error("end word position out of range");

    // header position stays inside the header
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bsfd_pkg::PH_HEADER |-> pos_reg < bsfd_pkg::HDR_BYTES)
        else $error("header position out of range");

endmodule

`default_nettype wire

### sv/bsfd_out_stage.sv
// Result register: holds one result transfer until the consumer takes it.
// Depends on bsfd_pkg.
`default_nettype none

module bsfd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire bsfd_pkg::result_t res,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output bsfd_pkg::result_t      out_res
);

    logic              valid_reg, valid_next;
    bsfd_pkg::result_t res_reg;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

### sv/byte_stream_frame_deframer.sv
// Top level of the byte stream frame deframer: input byte register and handshake.
// Depends on bsfd_pkg, bsfd_parser and bsfd_out_stage.
//
// Takes one byte per transfer and returns payload-byte and frame-status results.
// Sustained rate is one byte per clock: a byte waits in the input register, is
// parsed combinationally and its result, if any, is written to the output
// register, from which it can transfer out. The output register is the
// only limit: while it holds an untaken result, the next byte that would produce
// a result waits, and in_ready follows out_ready in the same cycle.
// Configuration writes take effect at the next clock.
`default_nettype none

module byte_stream_frame_deframer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         in_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    kind,
    output logic [7:0]                              payload_byte,
    output logic                                    payload_last,
    output logic [31:0]                             packet_id,
    output logic [7:0]                              data_type,
    output logic [31:0]                             payload_length,
    output logic [7:0]                              channel_id,
    output logic [2:0]                              status,
    input  wire logic                               cfg_we,
    input  wire logic [bsfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bsfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_free;
    logic              advance;
    logic              has_res;
    bsfd_pkg::result_t res;
    bsfd_pkg::result_t out_res;

    assign out_free = !out_valid || out_ready;
    // a byte with no result moves on even while the output is full
    assign advance  = in_valid_reg && (!has_res || out_free);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        priority if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= in_byte;
    end

    bsfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data      (in_byte_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res),
        .has_res   (has_res)
    );

    bsfd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_res),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign payload_byte   = out_res.payload_byte;
    assign payload_last   = out_res.payload_last;
    assign packet_id      = out_res.packet_id;
    assign data_type      = out_res.data_type;
    assign payload_length = out_res.payload_length;
    assign channel_id     = out_res.channel_id;
    assign status         = out_res.status;

    // a parsed byte with a result always shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_res |=> out_valid)
        else $error("result lost between parser and output register");

    // a held byte stays put until the parser takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte dropped while stalled");

endmodule

`default_nettype wire

### dv/tb_byte_stream_frame_deframer.sv
// Self-checking testbench for byte_stream_frame_deframer: frames go in as byte
// transfers, payload and status results are checked against a built-in frame parser.
// Depends on bsfd_pkg and the deframer RTL.
module tb_byte_stream_frame_deframer;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HDR_LEN     = 12;
    localparam int PHASE_BYTES = 200;
    localparam int DIR_ROWS    = 26;

    typedef enum logic [1:0] {IN_HEADER, IN_PAYLOAD, IN_TRAILER} parse_phase_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic [2:0]  code;
        logic [31:0] id;
        logic [7:0]  dtype;
        logic [31:0] len;
        logic [7:0]  chan;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] in_byte;
    logic out_valid;
    logic out_ready;
    logic kind;
    logic [7:0] payload_byte;
    logic payload_last;
    logic [31:0] packet_id;
    logic [7:0] data_type;
    logic [31:0] payload_length;
    logic [7:0] channel_id;
    logic [2:0] status;
    logic cfg_we;
    logic [bsfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bsfd_pkg::CFG_DATA_W-1:0] cfg_data;

    // Parser copy used for prediction
    parse_phase_t frm_phase;
    logic [bsfd_pkg::LEN_WIDTH-1:0] frm_pos;
    logic [15:0] frm_start;
    logic [31:0] frm_id;
    logic [7:0] frm_type;
    logic [31:0] frm_len;
    logic [7:0] frm_chan;
    logic [7:0] frm_end_hi;
    logic frm_zero_seen;
    logic [15:0] cfg_start_mark;
    logic [15:0] cfg_end_mark;
    logic [23:0] cfg_max_len;

    bsfd_pkg::result_t pending_results[$];
    bsfd_pkg::result_t pred_r;
    bsfd_pkg::result_t got_r;
    bsfd_pkg::result_t exp_r;
    bit pred_has;
    bit row_typed;
    bsfd_pkg::result_t row_result;
    bit quiet;
    bit phase_quiet;
    int bytes_sent;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Frame A: all-ones header except for a length one past the reset limit.
    // Frame B: all-zero frame, bad start and bad end together.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{8'hff, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'hff, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'hff, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'hff, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'hff, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'hff, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'hff, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h10, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h01, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'hff, 1'b1, bsfd_pkg::ST_TOO_LONG, 32'hffffffff, 8'hff, 32'h00001001, 8'hff},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b0, bsfd_pkg::ST_OK, 32'h0, 8'h0, 32'h0, 8'h0},
        '{8'h00, 1'b1, bsfd_pkg::ST_BAD_START, 32'h0, 8'h0, 32'h0, 8'h0}
    };

    byte_stream_frame_deframer uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .payload_byte(payload_byte),
        .payload_last(payload_last),
        .packet_id(packet_id),
        .data_type(data_type),
        .payload_length(payload_length),
        .channel_id(channel_id),
        .status(status),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic bsfd_pkg::result_t frame_status(input logic [2:0] code);
        bsfd_pkg::result_t s;
        s = '0;
        s.kind = bsfd_pkg::KIND_STATUS;
        s.packet_id = frm_id;
        s.data_type = frm_type;
        s.payload_length = frm_len;
        s.channel_id = frm_chan;
        s.status = code;
        return s;
    endfunction

    // Advance the parser copy by one byte; returns 1 when the byte yields a result
    function automatic bit deframe_step(input logic [7:0] b, output bsfd_pkg::result_t r);
        logic [32:0] next_pos;
        logic [15:0] end_word;
        r = '0;
        if (frm_phase == IN_PAYLOAD)
        begin
            if (b == 8'h00)
                frm_zero_seen = 1'b1;
            next_pos = 33'(frm_pos) + 33'd1;
            r.kind = bsfd_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.payload_last = (next_pos == {1'b0, frm_len});
            frm_pos = next_pos[bsfd_pkg::LEN_WIDTH-1:0];
            if (r.payload_last)
            begin
                frm_phase = IN_TRAILER;
                frm_pos = '0;
            end
            return 1'b1;
        end
        if (frm_phase == IN_TRAILER)
        begin
            if (frm_pos == '0)
            begin
                frm_end_hi = b;
                frm_pos = bsfd_pkg::LEN_WIDTH'(1);
                return 1'b0;
            end
            end_word = {frm_end_hi, b};
            if (frm_start != cfg_start_mark)
                r = frame_status(bsfd_pkg::ST_BAD_START);
            else if (end_word != cfg_end_mark)
                r = frame_status(bsfd_pkg::ST_BAD_END);
            else if (frm_zero_seen)
                r = frame_status(bsfd_pkg::ST_ZERO_BYTE);
            else
                r = frame_status(bsfd_pkg::ST_OK);
            frm_phase = IN_HEADER;
            frm_pos = '0;
            return 1'b1;
        end
        frm_phase = IN_HEADER;
        if (frm_pos >= HDR_LEN)
            frm_pos = '0;
        if (frm_pos == '0)
            frm_zero_seen = 1'b0;
        if (frm_pos < 2)
            frm_start = {frm_start[7:0], b};
        else if (frm_pos < 6)
            frm_id = {frm_id[23:0], b};
        else if (frm_pos == 6)
            frm_type = b;
        else if (frm_pos < 11)
            frm_len = {frm_len[23:0], b};
        else
            frm_chan = b;
        if (frm_pos + 1 < HDR_LEN)
        begin
            frm_pos = frm_pos + bsfd_pkg::LEN_WIDTH'(1);
            return 1'b0;
        end
        frm_pos = '0;
        if (frm_len > {8'h00, cfg_max_len} || frm_len[31:bsfd_pkg::LEN_WIDTH] != '0)
        begin
            r = frame_status(bsfd_pkg::ST_TOO_LONG);
            return 1'b1;
        end
        frm_phase = (frm_len == 0) ? IN_TRAILER : IN_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string what, input bsfd_pkg::result_t e,
                                 input bsfd_pkg::result_t g);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s at cycle %0d", what, cycle_count);
            $display("  exp kind=%0d byte=%02h last=%0d id=%08h type=%02h len=%08h ch=%02h st=%0d",
                     e.kind, e.payload_byte, e.payload_last, e.packet_id, e.data_type,
                     e.payload_length, e.channel_id, e.status);
            $display("  got kind=%0d byte=%02h last=%0d id=%08h type=%02h len=%08h ch=%02h st=%0d",
                     g.kind, g.payload_byte, g.payload_last, g.packet_id, g.data_type,
                     g.payload_length, g.channel_id, g.status);
        end
    endtask

    // Check result transfers first, then predict from the byte transfer of this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_r.kind = kind;
                got_r.payload_byte = payload_byte;
                got_r.payload_last = payload_last;
                got_r.packet_id = packet_id;
                got_r.data_type = data_type;
                got_r.payload_length = payload_length;
                got_r.channel_id = channel_id;
                got_r.status = status;
                if (pending_results.size() == 0)
                    note_mismatch("unexpected result", '0, got_r);
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got_r.kind !== exp_r.kind || got_r.payload_byte !== exp_r.payload_byte ||
                        got_r.payload_last !== exp_r.payload_last ||
                        got_r.packet_id !== exp_r.packet_id ||
                        got_r.data_type !== exp_r.data_type ||
                        got_r.payload_length !== exp_r.payload_length ||
                        got_r.channel_id !== exp_r.channel_id || got_r.status !== exp_r.status)
                        note_mismatch("result mismatch", exp_r, got_r);
                end
            end
            if (in_valid && in_ready)
            begin
                pred_has = deframe_step(in_byte, pred_r);
                if (row_typed)
                begin
                    pred_has = 1'b1;
                    pred_r = row_result;
                end
                if (pred_has)
                    pending_results.push_back(pred_r);
            end
        end
    end

    // Result side: random stalls
    initial
    begin
        int hold;
        out_ready = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready = 1'b0;
                hold--;
            end
            else
            begin
                out_ready = 1'b1;
                hold = pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bsfd_pkg::result_t res = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte = b;
        row_typed = typed;
        row_result = res;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic set_reg(input logic [bsfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsfd_pkg::CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            bsfd_pkg::REG_START_MARKER: cfg_start_mark = val[15:0];
            bsfd_pkg::REG_END_MARKER:   cfg_end_mark = val[15:0];
            bsfd_pkg::REG_MAX_PAYLOAD:  cfg_max_len = val[23:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    // One frame: mostly well-formed, some too long, truncated or pure noise
    task automatic send_frame();
        int mode;
        int i;
        int cut;
        logic [31:0] len;
        logic [31:0] id;
        logic [15:0] sw;
        logic [15:0] ew;
        logic [7:0] b;
        bit too_long;
        mode = $urandom_range(0, 99);
        quiet = phase_quiet || ($urandom_range(0, 4) == 0);
        if (mode < 10 && cfg_max_len <= 24'd255)
        begin
            repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
        end
        else
        begin
            sw = cfg_start_mark;
            ew = cfg_end_mark;
            if ($urandom_range(0, 9) == 0)
                sw = sw ^ 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 9) == 0)
                ew = ew ^ 16'($urandom_range(1, 65535));
            id = $urandom;
            too_long = (mode < 25);
            if (too_long)
            begin
                if (cfg_max_len == 24'hffffff || $urandom_range(0, 1) == 1)
                    len = {8'($urandom_range(1, 255)), 24'($urandom)};
                else
                    len = {8'h00, cfg_max_len} + 32'($urandom_range(1, 1000));
            end
            else if (mode >= 97)
                len = $urandom_range(0, (cfg_max_len < 200) ? cfg_max_len : 200);
            else
                len = $urandom_range(0, (cfg_max_len < 24) ? cfg_max_len : 24);
            // truncated payload: the end word lands inside the payload
            cut = (mode >= 25 && mode < 32) ? int'(len / 2) : int'(len);
            send_byte(sw[15:8]);
            send_byte(sw[7:0]);
            for (i = 24; i >= 0; i -= 8)
                send_byte(id[i +: 8]);
            send_byte(8'($urandom));
            for (i = 24; i >= 0; i -= 8)
                send_byte(len[i +: 8]);
            send_byte(8'($urandom));
            if (!too_long)
            begin
                for (i = 0; i < cut; i++)
                begin
                    b = 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 39) == 0)
                        b = 8'h00;
                    send_byte(b);
                end
                send_byte(ew[15:8]);
                send_byte(ew[7:0]);
            end
        end
        // fill until the parser is back at the first header byte
        while (!(frm_phase == IN_HEADER && frm_pos == '0))
            send_byte(8'($urandom));
    endtask

    initial
    begin
        int i;
        int p;
        bsfd_pkg::result_t typed_r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        row_typed = 1'b0;
        row_result = '0;
        quiet = 1'b0;
        phase_quiet = 1'b0;
        bytes_sent = 0;
        frm_phase = IN_HEADER;
        frm_pos = '0;
        frm_start = '0;
        frm_id = '0;
        frm_type = '0;
        frm_len = '0;
        frm_chan = '0;
        frm_end_hi = '0;
        frm_zero_seen = 1'b0;
        cfg_start_mark = bsfd_pkg::START_MARKER_RST;
        cfg_end_mark = bsfd_pkg::END_MARKER_RST;
        cfg_max_len = bsfd_pkg::MAX_PAYLOAD_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            typed_r = '0;
            typed_r.kind = bsfd_pkg::KIND_STATUS;
            typed_r.packet_id = dir_table[i].id;
            typed_r.data_type = dir_table[i].dtype;
            typed_r.payload_length = dir_table[i].len;
            typed_r.channel_id = dir_table[i].chan;
            typed_r.status = dir_table[i].code;
            send_byte(dir_table[i].b, dir_table[i].typed, typed_r);
        end
        in_valid = 1'b0;
        row_typed = 1'b0;
        wait_idle();

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    set_reg(bsfd_pkg::REG_START_MARKER, 24'h000000);
                    set_reg(bsfd_pkg::REG_END_MARKER, 24'h00ffff);
                    set_reg(bsfd_pkg::REG_MAX_PAYLOAD, 24'h000000);
                end
                1:
                begin
                    set_reg(bsfd_pkg::REG_START_MARKER, 24'h00ffff);
                    set_reg(bsfd_pkg::REG_END_MARKER, 24'h000000);
                    set_reg(bsfd_pkg::REG_MAX_PAYLOAD, 24'hffffff);
                end
                2:
                begin
                    set_reg(bsfd_pkg::REG_START_MARKER, 24'($urandom_range(0, 65535)));
                    set_reg(bsfd_pkg::REG_END_MARKER, 24'($urandom_range(0, 65535)));
                    set_reg(bsfd_pkg::REG_MAX_PAYLOAD, 24'($urandom_range(30, 255)));
                end
                3:
                begin
                    set_reg(bsfd_pkg::REG_START_MARKER, 24'(bsfd_pkg::START_MARKER_RST));
                    set_reg(bsfd_pkg::REG_END_MARKER, 24'(bsfd_pkg::END_MARKER_RST));
                    set_reg(bsfd_pkg::REG_MAX_PAYLOAD, bsfd_pkg::MAX_PAYLOAD_RST);
                end
                default:
                begin
                    set_reg(bsfd_pkg::REG_START_MARKER, 24'($urandom_range(0, 65535)));
                    set_reg(bsfd_pkg::REG_END_MARKER, 24'($urandom_range(0, 65535)));
                    set_reg(bsfd_pkg::REG_MAX_PAYLOAD, 24'($urandom_range(1, 40)));
                end
            endcase
            phase_quiet = (p == 4);
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES)
                send_frame();
            in_valid = 1'b0;
            row_typed = 1'b0;
            quiet = 1'b0;
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
